FILE: src/rgbhsv_pkg.sv
// ----------------------------------------------------------------------------
// rgbhsv_pkg: shared types and constants for the RGB to HSV converter
// Hue and saturation constants, divider widths and the reciprocal table used
// by the reciprocal-multiply dividers.
// ----------------------------------------------------------------------------
package rgbhsv_pkg;

    localparam int CHAN_W      = 8;
    localparam int HUE_W       = 15;
    localparam int SAT_W       = 16;

    localparam int HUE_SIXTH      = 3840;
    localparam int HUE_THIRD      = 7680;
    localparam int HUE_TWO_THIRDS = 15360;
    localparam int HUE_FULL       = 23040;

    localparam int RECIP_SHIFT = 24;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int RECIP_DEPTH = 1 << CHAN_W;

    localparam int SAT_NUM_W = 24;
    localparam int SAT_QUO_W = 16;
    localparam int HUE_NUM_W = 20;
    localparam int HUE_QUO_W = 12;

    typedef enum logic [1:0] {
        SEL_RED,
        SEL_GREEN,
        SEL_BLUE
    } max_sel_t;

    typedef struct packed {
        logic load_s2;
        logic load_s3;
        logic load_s4;
        logic load_s5;
    } rgbhsv_adv_t;

    typedef logic [RECIP_W-1:0] recip_tab_t [RECIP_DEPTH];

    // floor(2^RECIP_SHIFT / x) by shift and subtract; zero for x = 0
    function automatic logic [RECIP_W-1:0] recip_entry(input int unsigned x);
        logic [RECIP_W-1:0] quo;
        logic [RECIP_W:0]   rem;
        quo = '0;
        rem = '0;
        if (x != 0)
        begin
            for (int i = RECIP_SHIFT; i >= 0; i--)
            begin
                rem = {rem[RECIP_W-1:0], (i == RECIP_SHIFT) ? 1'b1 : 1'b0};
                if (rem >= (RECIP_W+1)'(x))
                begin
                    rem    = rem - (RECIP_W+1)'(x);
                    quo[i] = 1'b1;
                end
            end
        end
        return quo;
    endfunction

    function automatic recip_tab_t build_recip_table();
        recip_tab_t tab;
        for (int i = 0; i < RECIP_DEPTH; i++)
        begin
            tab[i] = recip_entry(i);
        end
        return tab;
    endfunction

    localparam recip_tab_t RECIP_TABLE = build_recip_table();

endpackage

FILE: src/rgbhsv_div.sv
// ----------------------------------------------------------------------------
// rgbhsv_div: pipelined reciprocal-multiply divider
// Four stages: reciprocal lookup, estimate multiply, back multiply, and a
// single compare-subtract correction giving the floor quotient and a
// nonzero-remainder flag. A zero divisor yields a zero quotient.
// ----------------------------------------------------------------------------
module rgbhsv_div
    import rgbhsv_pkg::*;
#(
    parameter int NUM_W = SAT_NUM_W,
    parameter int QUO_W = SAT_QUO_W
)
(
    input  logic              clk,
    input  rgbhsv_adv_t       adv,
    input  logic [NUM_W-1:0]  num,
    input  logic [CHAN_W-1:0] den,
    output logic [QUO_W-1:0]  quo,
    output logic              rem_nz
);

    localparam int PROD_W = NUM_W + RECIP_W;

    logic [NUM_W-1:0]   num_s2_reg;
    logic [CHAN_W-1:0]  den_s2_reg;
    logic [RECIP_W-1:0] recip_s2_reg;

    logic [NUM_W-1:0]   num_s3_reg;
    logic [CHAN_W-1:0]  den_s3_reg;
    logic [QUO_W-1:0]   est_s3_reg;

    logic [NUM_W-1:0]   num_s4_reg;
    logic [CHAN_W-1:0]  den_s4_reg;
    logic [QUO_W-1:0]   est_s4_reg;
    logic [NUM_W-1:0]   back_s4_reg;

    logic [QUO_W-1:0]   quo_reg;
    logic               rem_nz_reg;

    logic [PROD_W-1:0]       est_prod;
    logic [QUO_W+CHAN_W-1:0] back_prod;
    logic [NUM_W-1:0]        rem;
    logic                    fix;

    assign est_prod  = PROD_W'(num_s2_reg) * PROD_W'(recip_s2_reg);
    assign back_prod = (QUO_W+CHAN_W)'(est_s3_reg) * (QUO_W+CHAN_W)'(den_s3_reg);
    assign rem       = num_s4_reg - back_s4_reg;
    assign fix       = (den_s4_reg != '0) && (rem >= NUM_W'(den_s4_reg));

    always_ff @(posedge clk)
    begin
        if (adv.load_s2)
        begin
            num_s2_reg   <= num;
            den_s2_reg   <= den;
            recip_s2_reg <= RECIP_TABLE[den];
        end
        if (adv.load_s3)
        begin
            num_s3_reg <= num_s2_reg;
            den_s3_reg <= den_s2_reg;
            est_s3_reg <= est_prod[RECIP_SHIFT +: QUO_W];
        end
        if (adv.load_s4)
        begin
            num_s4_reg  <= num_s3_reg;
            den_s4_reg  <= den_s3_reg;
            est_s4_reg  <= est_s3_reg;
            back_s4_reg <= NUM_W'(back_prod);
        end
        if (adv.load_s5)
        begin
            quo_reg    <= est_s4_reg + QUO_W'(fix);
            rem_nz_reg <= fix ? (rem != NUM_W'(den_s4_reg)) : (rem != '0);
        end
    end

    assign quo    = quo_reg;
    assign rem_nz = rem_nz_reg;

endmodule

FILE: src/rgb_to_hsv_top.sv
// Throughput: one pixel per clock while out_stall is low; six register stages, each
// advancing on its own so that bubbles collapse while the output is stalled.
// Division uses a reciprocal table, an estimate multiply, a back multiply and one correction step.
// Reset (rst_n low, asynchronous) clears all stage valid bits; data is not reset.
// ----------------------------------------------------------------------------
// rgb_to_hsv_top: 8-bit RGB to HSV pixel converter
// Max/min select, saturation and hue dividers, hue offset and wrap, output
// register with valid/stall handshake.
// ----------------------------------------------------------------------------
module rgb_to_hsv_top
    import rgbhsv_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [CHAN_W-1:0] red_in,
    input  logic [CHAN_W-1:0] green_in,
    input  logic [CHAN_W-1:0] blue_in,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [HUE_W-1:0]  hue_out,
    output logic [SAT_W-1:0]  sat_out,
    output logic [CHAN_W-1:0] val_out
);

    localparam int STAGES = 6;

    typedef struct packed {
        logic [CHAN_W-1:0] val;
        max_sel_t          sel;
        logic              neg;
    } side_t;

    logic [STAGES:1] valid_reg;
    logic [STAGES:1] en;

    logic [CHAN_W-1:0] max_c;
    logic [CHAN_W-1:0] min_c;
    max_sel_t          sel_c;
    logic signed [CHAN_W:0] diff_c;

    logic [CHAN_W-1:0] max_s1_reg;
    logic [CHAN_W-1:0] d_s1_reg;
    max_sel_t          sel_s1_reg;
    logic              neg_s1_reg;
    logic [CHAN_W-1:0] mag_s1_reg;

    side_t side_reg [2:5];

    logic [SAT_NUM_W-1:0] sat_num;
    logic [HUE_NUM_W-1:0] hue_num;
    logic [SAT_QUO_W-1:0] sat_quo;
    logic [HUE_QUO_W-1:0] hue_quo;
    logic                 sat_nz;
    logic                 hue_nz;
    rgbhsv_adv_t          adv;

    logic [HUE_QUO_W:0]  hue_mag;
    logic signed [15:0]  hue_off;
    logic signed [15:0]  hue_sum;
    logic signed [15:0]  hue_wrap;

    logic [HUE_W-1:0]  hue_reg;
    logic [SAT_W-1:0]  sat_reg;
    logic [CHAN_W-1:0] val_reg;

    // per-stage advance: a stage loads when empty or when the next one moves
    always_comb
    begin
        en[STAGES] = !valid_reg[STAGES] || !out_stall;
        for (int k = STAGES - 1; k >= 1; k--)
        begin
            en[k] = !valid_reg[k] || en[k+1];
        end
    end

    assign in_stall = !en[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[1])
            begin
                valid_reg[1] <= in_valid;
            end
            for (int k = 2; k <= STAGES; k++)
            begin
                if (en[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // stage 1: largest channel, spread and signed hue difference
    always_comb
    begin
        if (red_in >= green_in && red_in >= blue_in)
        begin
            sel_c  = SEL_RED;
            max_c  = red_in;
            diff_c = $signed({1'b0, green_in}) - $signed({1'b0, blue_in});
        end
        else if (green_in >= blue_in)
        begin
            sel_c  = SEL_GREEN;
            max_c  = green_in;
            diff_c = $signed({1'b0, blue_in}) - $signed({1'b0, red_in});
        end
        else
        begin
            sel_c  = SEL_BLUE;
            max_c  = blue_in;
            diff_c = $signed({1'b0, red_in}) - $signed({1'b0, green_in});
        end
        min_c = red_in;
        if (green_in < min_c)
        begin
            min_c = green_in;
        end
        if (blue_in < min_c)
        begin
            min_c = blue_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            max_s1_reg <= max_c;
            d_s1_reg   <= max_c - min_c;
            sel_s1_reg <= sel_c;
            neg_s1_reg <= diff_c[CHAN_W];
            mag_s1_reg <= diff_c[CHAN_W] ? CHAN_W'(-diff_c) : CHAN_W'(diff_c);
        end
    end

    // stages 2 to 5: dividers, side data travels alongside
    assign sat_num = {d_s1_reg, 16'h0000} - SAT_NUM_W'(d_s1_reg);
    assign hue_num = HUE_NUM_W'(mag_s1_reg) * HUE_NUM_W'(HUE_SIXTH);

    assign adv.load_s2 = en[2];
    assign adv.load_s3 = en[3];
    assign adv.load_s4 = en[4];
    assign adv.load_s5 = en[5];

    rgbhsv_div #(
        .NUM_W (SAT_NUM_W),
        .QUO_W (SAT_QUO_W)
    ) u_sat_div (
        .clk    (clk),
        .adv    (adv),
        .num    (sat_num),
        .den    (max_s1_reg),
        .quo    (sat_quo),
        .rem_nz (sat_nz)
    );

    rgbhsv_div #(
        .NUM_W (HUE_NUM_W),
        .QUO_W (HUE_QUO_W)
    ) u_hue_div (
        .clk    (clk),
        .adv    (adv),
        .num    (hue_num),
        .den    (d_s1_reg),
        .quo    (hue_quo),
        .rem_nz (hue_nz)
    );

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            side_reg[2] <= '{val: max_s1_reg, sel: sel_s1_reg, neg: neg_s1_reg};
        end
        for (int k = 3; k <= 5; k++)
        begin
            if (en[k])
            begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    // stage 6: floor of negative quotient, sector offset and wrap
    always_comb
    begin
        hue_mag = (HUE_QUO_W+1)'(hue_quo) + (HUE_QUO_W+1)'(hue_nz);
        hue_off = side_reg[5].neg ? -$signed(16'(hue_mag)) : $signed(16'(hue_quo));
        case (side_reg[5].sel)
            SEL_RED:   hue_sum = hue_off;
            SEL_GREEN: hue_sum = 16'(HUE_THIRD) + hue_off;
            SEL_BLUE:  hue_sum = 16'(HUE_TWO_THIRDS) + hue_off;
            default:   hue_sum = hue_off;
        endcase
        hue_wrap = (hue_sum < 0) ? hue_sum + 16'(HUE_FULL) : hue_sum;
    end

    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            hue_reg <= HUE_W'(hue_wrap);
            sat_reg <= sat_quo;
            val_reg <= side_reg[5].val;
        end
    end

    assign out_valid = valid_reg[STAGES];
    assign hue_out   = hue_reg;
    assign sat_out   = sat_reg;
    assign val_out   = val_reg;

endmodule

FILE: src/rgbhsv_checker.sv
// ----------------------------------------------------------------------------
// rgbhsv_checker: port-level checks for the RGB to HSV converter
// Watches the top level's ports and flags handshake slips and impossible
// result transactions.
// ----------------------------------------------------------------------------
module rgbhsv_checker
    import rgbhsv_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input logic              out_valid,
    input logic              out_stall,
    input logic [HUE_W-1:0]  hue_out,
    input logic [SAT_W-1:0]  sat_out,
    input logic [CHAN_W-1:0] val_out
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output transaction dropped while stalled");

    a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> hue_out < HUE_W'(HUE_FULL))
        else $error("hue out of range");

    a_black: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && val_out == '0 |-> sat_out == '0 && hue_out == '0)
        else $error("black pixel with nonzero hue or saturation");

    a_gray: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && sat_out == '0 |-> hue_out == '0)
        else $error("gray pixel with nonzero hue");

    a_no_stall_empty: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_stall && $past(in_valid || out_valid))
        else $error("input stalled with no backpressure");

endmodule

bind rgb_to_hsv_top rgbhsv_checker u_rgbhsv_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .hue_out   (hue_out),
    .sat_out   (sat_out),
    .val_out   (val_out)
);
